// File: hw/rtl/i2c_bit_level_master_defines.svh
// Assertion macros used by the I2C bit-level master RTL.
`ifndef I2C_BIT_LEVEL_MASTER_DEFINES_SVH
`define I2C_BIT_LEVEL_MASTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define I2CBLM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define I2CBLM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/i2cblm_pkg.sv
// Types, constants and phase drive function of the I2C bit-level master.
package i2cblm_pkg;

    typedef enum logic [3:0] {
        OP_IDLE  = 4'd0,
        OP_START = 4'd1,
        OP_STOP  = 4'd2,
        OP_REP   = 4'd3,
        OP_WRITE = 4'd4,
        OP_READ  = 4'd5,
        OP_ACK   = 4'd6,
        OP_NACK  = 4'd7,
        OP_CLEAR = 4'd8
    } t_op;

    localparam logic [15:0] HALF_PERIOD_RST = 16'd210;
    localparam logic [3:0]  WRITE_LAST_BIT  = 4'd8;
    localparam logic [3:0]  READ_LAST_BIT   = 4'd7;
    localparam logic [3:0]  ONE_LAST_BIT    = 4'd0;
    localparam logic [1:0]  SUB_SCL_LOW     = 2'd0;
    localparam logic [1:0]  SUB_SDA_SET     = 2'd1;
    localparam logic [1:0]  SUB_SCL_HIGH    = 2'd2;
    localparam logic [1:0]  START_LAST_SUB  = 2'd1;
    localparam logic [1:0]  FOUR_LAST_SUB   = 2'd3;
    localparam int          ERR_NO_ACK      = 0;
    localparam int          ERR_MISMATCH    = 1;

    typedef struct packed {
        logic [3:0] cmd;
        logic [7:0] wr_data;
        logic       sda_in;
    } t_item;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rd_data;
        logic       err_mismatch;
        logic       err_no_ack;
    } t_res;

    typedef struct packed {
        logic scl;
        logic sda;
    } t_lines;

    // Bus levels for one phase; start/stop/repstart use sub as the phase number.
    function automatic t_lines drive(t_op op, logic [1:0] sub, logic msb, t_lines cur);
        t_lines lines;
        lines = cur;
        case (op)
            OP_START: begin
                if (sub == 2'd0) begin
                    lines.scl = 1'b1;
                    lines.sda = 1'b1;
                end else begin
                    lines.sda = 1'b0;
                end
            end
            OP_STOP, OP_REP: begin
                if (!sub[0]) begin
                    lines.scl = (sub != 2'd0);
                end else if (op == OP_STOP) begin
                    lines.sda = (sub != 2'd1);
                end else begin
                    lines.sda = (sub == 2'd1);
                end
            end
            default: begin
                if (sub == SUB_SCL_LOW) begin
                    lines.scl = 1'b0;
                end else if (sub == SUB_SCL_HIGH) begin
                    lines.scl = 1'b1;
                end else if (op == OP_WRITE) begin
                    lines.sda = msb;
                end else if (op == OP_ACK) begin
                    lines.sda = 1'b0;
                end else begin
                    lines.sda = 1'b1;
                end
            end
        endcase
        return lines;
    endfunction

endpackage

// File: hw/rtl/i2cblm_in_reg.sv
// Input register stage: holds one accepted transaction until the core takes it.
module i2cblm_in_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  i2cblm_pkg::t_item   i_item,
    input  logic                i_take,
    output logic                o_vld,
    output i2cblm_pkg::t_item   o_item
);

    logic              r_vld;
    i2cblm_pkg::t_item r_item;
    logic              w_accept;

    assign o_stall  = r_vld && !i_take;
    assign w_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_accept) begin
            r_vld <= 1'b1;
        end else if (i_take) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

// File: hw/rtl/i2cblm_core.sv
// Bus phase sequencer: state registers and next-state logic for one item per step.
module i2cblm_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_wdata,
    input  logic                i_step,
    input  i2cblm_pkg::t_item   i_item,
    output i2cblm_pkg::t_res    o_res
);

    i2cblm_pkg::t_op    r_op, n_op;
    logic [1:0]         r_sub, n_sub;
    logic [3:0]         r_bit, n_bit;
    logic [15:0]        r_hold, n_hold;
    logic [7:0]         r_shift, n_shift;
    logic [7:0]         r_rd, n_rd;
    i2cblm_pkg::t_lines r_lines, n_lines;
    logic [1:0]         r_err, n_err;
    logic [15:0]        r_half;

    logic        w_cmd_start;
    logic        w_clear;
    logic [15:0] w_hold_dec;
    logic [15:0] w_load;
    logic        w_expire;
    logic        w_bit_op;
    logic        w_sample;
    logic [1:0]  w_last_sub;
    logic [3:0]  w_last_bit;
    logic        w_finish;
    logic        w_done;

    assign w_clear     = (r_op == i2cblm_pkg::OP_IDLE) && (i_item.cmd == i2cblm_pkg::OP_CLEAR);
    assign w_cmd_start = (r_op == i2cblm_pkg::OP_IDLE) &&
                         (i_item.cmd >= i2cblm_pkg::OP_START) &&
                         (i_item.cmd <= i2cblm_pkg::OP_NACK);
    assign w_hold_dec  = (r_hold != 16'd0) ? r_hold - 16'd1 : 16'd0;
    assign w_load      = (r_half == 16'd0) ? 16'd1 : r_half;
    assign w_expire    = (r_op != i2cblm_pkg::OP_IDLE) && (w_hold_dec == 16'd0);
    assign w_bit_op    = r_op inside {i2cblm_pkg::OP_WRITE, i2cblm_pkg::OP_READ,
                                      i2cblm_pkg::OP_ACK, i2cblm_pkg::OP_NACK};
    assign w_sample    = w_expire && (r_sub == i2cblm_pkg::SUB_SCL_HIGH) &&
                         ((r_op == i2cblm_pkg::OP_WRITE) || (r_op == i2cblm_pkg::OP_READ));

    always_comb begin
        case (r_op)
            i2cblm_pkg::OP_START:                  w_last_sub = i2cblm_pkg::START_LAST_SUB;
            i2cblm_pkg::OP_STOP, i2cblm_pkg::OP_REP: w_last_sub = i2cblm_pkg::FOUR_LAST_SUB;
            default:                               w_last_sub = i2cblm_pkg::SUB_SCL_HIGH;
        endcase
        case (r_op)
            i2cblm_pkg::OP_WRITE: w_last_bit = i2cblm_pkg::WRITE_LAST_BIT;
            i2cblm_pkg::OP_READ:  w_last_bit = i2cblm_pkg::READ_LAST_BIT;
            default:              w_last_bit = i2cblm_pkg::ONE_LAST_BIT;
        endcase
    end

    assign w_finish = w_expire && (r_sub == w_last_sub) && (!w_bit_op || (r_bit == w_last_bit));
    assign w_done   = w_clear || w_finish;

    // Next operation.
    always_comb begin
        n_op = r_op;
        if (w_cmd_start) begin
            n_op = i2cblm_pkg::t_op'(i_item.cmd);
        end else if (w_finish) begin
            n_op = i2cblm_pkg::OP_IDLE;
        end
    end

    // Phase counters, shifter, bus levels and flags.
    always_comb begin
        n_sub   = r_sub;
        n_bit   = r_bit;
        n_hold  = r_hold;
        n_shift = r_shift;
        n_rd    = r_rd;
        n_lines = r_lines;
        n_err   = r_err;
        if (w_clear) begin
            n_err = 2'b00;
        end else if (w_cmd_start) begin
            n_sub  = 2'd0;
            n_bit  = 4'd0;
            n_hold = w_load;
            if (i_item.cmd == i2cblm_pkg::OP_WRITE) begin
                n_shift = i_item.wr_data;
            end else if (i_item.cmd == i2cblm_pkg::OP_READ) begin
                n_shift = 8'd0;
            end
            n_lines = i2cblm_pkg::drive(i2cblm_pkg::t_op'(i_item.cmd), 2'd0,
                                        n_shift[7], r_lines);
        end else if (r_op != i2cblm_pkg::OP_IDLE) begin
            n_hold = w_hold_dec;
            if (w_sample) begin
                if (r_op == i2cblm_pkg::OP_READ) begin
                    n_shift = {r_shift[6:0], i_item.sda_in};
                end else if (r_bit == i2cblm_pkg::WRITE_LAST_BIT) begin
                    if (i_item.sda_in) begin
                        n_err[i2cblm_pkg::ERR_NO_ACK] = 1'b1;
                    end
                end else begin
                    if (r_shift[7] != i_item.sda_in) begin
                        n_err[i2cblm_pkg::ERR_MISMATCH] = 1'b1;
                    end
                    n_shift = {r_shift[6:0], 1'b1};
                end
            end
            if (w_finish) begin
                if (r_op == i2cblm_pkg::OP_READ) begin
                    n_rd = n_shift;
                end
                n_sub  = 2'd0;
                n_bit  = 4'd0;
                n_hold = 16'd0;
            end else if (w_expire) begin
                // Advance to the next phase and drive it.
                if (w_bit_op && (r_sub == i2cblm_pkg::SUB_SCL_HIGH)) begin
                    n_sub = i2cblm_pkg::SUB_SCL_LOW;
                    n_bit = r_bit + 4'd1;
                end else begin
                    n_sub = r_sub + 2'd1;
                end
                n_hold  = w_load;
                n_lines = i2cblm_pkg::drive(r_op, n_sub, n_shift[7], r_lines);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op    <= i2cblm_pkg::OP_IDLE;
            r_sub   <= 2'd0;
            r_bit   <= 4'd0;
            r_hold  <= 16'd0;
            r_shift <= 8'd0;
            r_rd    <= 8'd0;
            r_lines <= '{scl: 1'b1, sda: 1'b1};
            r_err   <= 2'b00;
        end else if (i_step) begin
            r_op    <= n_op;
            r_sub   <= n_sub;
            r_bit   <= n_bit;
            r_hold  <= n_hold;
            r_shift <= n_shift;
            r_rd    <= n_rd;
            r_lines <= n_lines;
            r_err   <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= i2cblm_pkg::HALF_PERIOD_RST;
        end else if (i_cfg_we) begin
            r_half <= i_cfg_wdata;
        end
    end

    always_comb begin
        o_res.scl_out      = n_lines.scl;
        o_res.sda_out      = n_lines.sda;
        o_res.busy_res     = (n_op != i2cblm_pkg::OP_IDLE);
        o_res.done_res     = w_done;
        o_res.rd_data      = n_rd;
        o_res.err_mismatch = n_err[i2cblm_pkg::ERR_MISMATCH];
        o_res.err_no_ack   = n_err[i2cblm_pkg::ERR_NO_ACK];
    end

endmodule

// File: hw/rtl/i2cblm_out_reg.sv
// Result register: holds one result transaction until the consumer takes it.
module i2cblm_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  i2cblm_pkg::t_res   i_res,
    input  logic               i_stall,
    output logic               o_valid,
    output logic               o_free,
    output i2cblm_pkg::t_res   o_res
);

    logic             r_vld;
    i2cblm_pkg::t_res r_res;

    assign o_free = !r_vld || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (!i_stall) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_vld;
    assign o_res   = r_res;

endmodule

// File: hw/rtl/i2c_bit_level_master.sv
// Top level of the I2C bit-level master.
//
//   channel   direction  handshake                 payload
//   input     in         i_in_valid / o_in_stall   i_cmd, i_wr_data, i_sda_in
//   result    out        o_out_valid / i_out_stall o_scl_out .. o_err_no_ack
//   config    in         i_cfg_we                  i_cfg_wdata (half_period)
//
// One transaction in, one result out; a new transaction is taken every cycle while the result side is not stalled.
// A transaction passes the input register, then one pass of the phase sequencer
// into the result register.
// Reset (synchronous, active low) idles the bus with both lines released and
// half_period at 210.
// A stall on the result side holds the result register and, once the input
// register is full, raises o_in_stall.
`include "i2c_bit_level_master_defines.svh"

module i2c_bit_level_master (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [3:0]  i_cmd,
    input  logic [7:0]  i_wr_data,
    input  logic        i_sda_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_scl_out,
    output logic        o_sda_out,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [7:0]  o_rd_data,
    output logic        o_err_mismatch,
    output logic        o_err_no_ack
);

    i2cblm_pkg::t_item w_in_item;
    i2cblm_pkg::t_item w_item;
    i2cblm_pkg::t_res  w_core_res;
    i2cblm_pkg::t_res  w_out_res;
    logic              w_in_vld;
    logic              w_out_free;
    logic              w_step;

    assign w_in_item = '{cmd: i_cmd, wr_data: i_wr_data, sda_in: i_sda_in};
    assign w_step    = w_in_vld && w_out_free;

    i2cblm_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (w_in_item),
        .i_take  (w_step),
        .o_vld   (w_in_vld),
        .o_item  (w_item)
    );

    i2cblm_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (w_step),
        .i_item      (w_item),
        .o_res       (w_core_res)
    );

    i2cblm_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_step),
        .i_res   (w_core_res),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_free  (w_out_free),
        .o_res   (w_out_res)
    );

    assign o_scl_out      = w_out_res.scl_out;
    assign o_sda_out      = w_out_res.sda_out;
    assign o_busy_res     = w_out_res.busy_res;
    assign o_done_res     = w_out_res.done_res;
    assign o_rd_data      = w_out_res.rd_data;
    assign o_err_mismatch = w_out_res.err_mismatch;
    assign o_err_no_ack   = w_out_res.err_no_ack;

    `I2CBLM_ASSERT_NEXT(a_step_fills_out, i_clk, !i_rst_n, w_step, o_out_valid, "step lost result")
    `I2CBLM_ASSERT_NOW(a_done_not_busy, i_clk, !i_rst_n, o_out_valid, !(o_done_res && o_busy_res), "done while busy")
    `I2CBLM_ASSERT_NOW(a_full_stalls_in, i_clk, !i_rst_n, o_out_valid && i_out_stall && w_in_vld, o_in_stall, "input not stalled")

endmodule

// File: tb/i2c_bus_checker.sv
`timescale 1ns / 100ps
// Checker for the I2C bit-level master: predicts each result and compares the output stream.
module i2c_bus_checker
    import i2cblm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        o_in_stall,
    input  logic [3:0]  i_cmd,
    input  logic [7:0]  i_wr_data,
    input  logic        i_sda_in,
    input  logic        o_out_valid,
    input  logic        i_out_stall,
    input  logic        o_scl_out,
    input  logic        o_sda_out,
    input  logic        o_busy_res,
    input  logic        o_done_res,
    input  logic [7:0]  o_rd_data,
    input  logic        o_err_mismatch,
    input  logic        o_err_no_ack,
    output int          o_fail_count,
    output int          o_outstanding,
    output logic        o_bus_idle,
    output t_op         o_bus_op,
    output logic [4:0]  o_bus_phase,
    output logic        o_bus_sda
);

    localparam int REPORT_LIMIT    = 10;
    localparam int START_PHASES    = 2;
    localparam int BUS_EDGE_PHASES = 4;
    localparam int WRITE_PHASES    = 27;
    localparam int READ_PHASES     = 24;
    localparam int BIT_PHASES      = 3;

    // Predicted state of the master
    t_op         m_op;
    logic [4:0]  m_phase;
    logic [15:0] m_hold;
    logic [15:0] m_half;
    logic [7:0]  m_shift;
    logic [7:0]  m_read;
    logic        m_scl;
    logic        m_sda;
    logic [1:0]  m_err;

    t_res line_state_q[$];
    int   mismatch_count;
    int   result_count;

    // Set the bus lines for phase p of op
    task automatic drive_lines(input t_op op, input int p);
        logic [1:0] slot;
        slot = 2'(p % 3);
        case (op)
            OP_START: begin
                if (p == 0) begin
                    m_scl = 1'b1;
                    m_sda = 1'b1;
                end else begin
                    m_sda = 1'b0;
                end
            end
            OP_STOP, OP_REP: begin
                if (p % 2 == 0) begin
                    m_scl = (p != 0);
                end else if (op == OP_STOP) begin
                    m_sda = (p != 1);
                end else begin
                    m_sda = (p == 1);
                end
            end
            default: begin
                if (slot == SUB_SCL_LOW) begin
                    m_scl = 1'b0;
                end else if (slot == SUB_SCL_HIGH) begin
                    m_scl = 1'b1;
                end else if (op == OP_WRITE) begin
                    m_sda = m_shift[7];
                end else begin
                    m_sda = (op != OP_ACK);
                end
            end
        endcase
    endtask

    // Advance the master by one item and return the line and status snapshot
    task automatic advance_master(input t_item it, output t_res r);
        logic done;
        logic fin;
        int   p;
        int   total;
        done = 1'b0;
        if (m_op == OP_IDLE) begin
            if (it.cmd == OP_CLEAR) begin
                m_err = 2'b00;
                done  = 1'b1;
            end else if (it.cmd >= OP_START && it.cmd <= OP_NACK) begin
                m_op    = t_op'(it.cmd);
                m_phase = '0;
                if (m_op == OP_WRITE) begin
                    m_shift = it.wr_data;
                end else if (m_op == OP_READ) begin
                    m_shift = '0;
                end
                drive_lines(m_op, 0);
                m_hold = (m_half == 16'd0) ? 16'd1 : m_half;
            end
        end else begin
            if (m_hold != 16'd0) m_hold = m_hold - 16'd1;
            if (m_hold == 16'd0) begin
                p   = m_phase;
                fin = 1'b0;
                // sample at the end of the SCL-high phase of a data bit
                if ((m_op == OP_WRITE || m_op == OP_READ) && p % 3 == SUB_SCL_HIGH) begin
                    if (m_op == OP_READ) begin
                        m_shift = {m_shift[6:0], it.sda_in};
                    end else if (p / 3 == WRITE_LAST_BIT) begin
                        if (it.sda_in) m_err[ERR_NO_ACK] = 1'b1;
                        fin = 1'b1;
                    end else begin
                        if (m_shift[7] != it.sda_in) m_err[ERR_MISMATCH] = 1'b1;
                        m_shift = {m_shift[6:0], 1'b1};
                    end
                end
                p++;
                case (m_op)
                    OP_START:        total = START_PHASES;
                    OP_STOP, OP_REP: total = BUS_EDGE_PHASES;
                    OP_WRITE:        total = WRITE_PHASES;
                    OP_READ:         total = READ_PHASES;
                    default:         total = BIT_PHASES;
                endcase
                if (p >= total) fin = 1'b1;
                if (fin) begin
                    if (m_op == OP_READ) m_read = m_shift;
                    m_op    = OP_IDLE;
                    m_phase = '0;
                    m_hold  = '0;
                    done    = 1'b1;
                end else begin
                    m_phase = p[4:0];
                    drive_lines(m_op, p);
                    m_hold = (m_half == 16'd0) ? 16'd1 : m_half;
                end
            end
        end
        r.scl_out      = m_scl;
        r.sda_out      = m_sda;
        r.busy_res     = (m_op != OP_IDLE);
        r.done_res     = done;
        r.rd_data      = m_read;
        r.err_mismatch = m_err[ERR_MISMATCH];
        r.err_no_ack   = m_err[ERR_NO_ACK];
    endtask

    always @(posedge i_clk) begin : watch
        t_item item;
        t_res  want;
        t_res  got;
        if (!i_rst_n) begin
            m_half  = HALF_PERIOD_RST;
            m_op    = OP_IDLE;
            m_phase = '0;
            m_hold  = '0;
            m_shift = '0;
            m_read  = '0;
            m_scl   = 1'b1;
            m_sda   = 1'b1;
            m_err   = 2'b00;
            line_state_q.delete();
            mismatch_count = 0;
            result_count   = 0;
        end else begin
            if (i_cfg_we) m_half = i_cfg_wdata;
            // compare before predicting: a result never stems from this edge's input
            if (o_out_valid && !i_out_stall) begin
                got.scl_out      = o_scl_out;
                got.sda_out      = o_sda_out;
                got.busy_res     = o_busy_res;
                got.done_res     = o_done_res;
                got.rd_data      = o_rd_data;
                got.err_mismatch = o_err_mismatch;
                got.err_no_ack   = o_err_no_ack;
                if (line_state_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("result %0d arrived with nothing expected", result_count);
                    end
                end else begin
                    want = line_state_q.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT) begin
                            $display({"result %0d mismatch: expected scl %b sda %b busy %b ",
                                      "done %b rd %h mism %b noack %b, actual scl %b sda %b ",
                                      "busy %b done %b rd %h mism %b noack %b"},
                                     result_count, want.scl_out, want.sda_out,
                                     want.busy_res, want.done_res, want.rd_data,
                                     want.err_mismatch, want.err_no_ack, got.scl_out,
                                     got.sda_out, got.busy_res, got.done_res, got.rd_data,
                                     got.err_mismatch, got.err_no_ack);
                        end
                    end
                end
                result_count++;
            end
            if (i_in_valid && !o_in_stall) begin
                item.cmd     = i_cmd;
                item.wr_data = i_wr_data;
                item.sda_in  = i_sda_in;
                advance_master(item, want);
                line_state_q.push_back(want);
            end
        end
        o_fail_count  <= mismatch_count;
        o_outstanding <= line_state_q.size();
        o_bus_idle    <= (m_op == OP_IDLE);
        o_bus_op      <= m_op;
        o_bus_phase   <= m_phase;
        o_bus_sda     <= m_sda;
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// Testbench top for the I2C bit-level master: bus stimulus, stalls and the verdict.
module tb;
    import i2cblm_pkg::*;

    typedef enum int {
        SDA_BUS,
        SDA_LOW,
        SDA_HIGH,
        SDA_RANDOM
    } t_sda_src;

    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int ITEM_TARGET    = 1950;
    localparam int FINAL_ITEMS    = 12;
    localparam int SEGMENTS       = 6;
    localparam int ACK_SLOT_PHASE = 24;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [3:0]  i_cmd;
    logic [7:0]  i_wr_data;
    logic        i_sda_in;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_scl_out;
    logic        o_sda_out;
    logic        o_busy_res;
    logic        o_done_res;
    logic [7:0]  o_rd_data;
    logic        o_err_mismatch;
    logic        o_err_no_ack;

    int          fail_count;
    int          outstanding;
    logic        bus_idle;
    t_op         bus_op;
    logic [4:0]  bus_phase;
    logic        bus_sda;

    bit          gaps_on  = 1'b1;
    bit          stall_on = 1'b1;
    bit          noise_on = 1'b0;
    bit          flip_on  = 1'b0;
    bit          ack_low  = 1'b1;
    bit          last_inert = 1'b1;
    t_sda_src    sda_src  = SDA_BUS;
    int          pushed   = 0;
    int          stall_left = 0;
    int          cycles   = 0;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    i2c_bit_level_master u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_wr_data      (i_wr_data),
        .i_sda_in       (i_sda_in),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_scl_out      (o_scl_out),
        .o_sda_out      (o_sda_out),
        .o_busy_res     (o_busy_res),
        .o_done_res     (o_done_res),
        .o_rd_data      (o_rd_data),
        .o_err_mismatch (o_err_mismatch),
        .o_err_no_ack   (o_err_no_ack)
    );

    i2c_bus_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_wr_data      (i_wr_data),
        .i_sda_in       (i_sda_in),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_scl_out      (o_scl_out),
        .o_sda_out      (o_sda_out),
        .o_busy_res     (o_busy_res),
        .o_done_res     (o_done_res),
        .o_rd_data      (o_rd_data),
        .o_err_mismatch (o_err_mismatch),
        .o_err_no_ack   (o_err_no_ack),
        .o_fail_count   (fail_count),
        .o_outstanding  (outstanding),
        .o_bus_idle     (bus_idle),
        .o_bus_op       (bus_op),
        .o_bus_phase    (bus_phase),
        .o_bus_sda      (bus_sda)
    );

    // Random result-side stall bursts while stall_on is set
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (stall_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 2);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Offer one item and hold it until the input register accepts it
    task automatic push_item(input logic [3:0] c, input logic [7:0] d);
        logic sda_bit;
        logic slave;
        if (gaps_on && $urandom_range(0, 9) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        // slave pulls the ack slot low when ack_low is set, or drives random read data
        slave = 1'b1;
        if (bus_op == OP_WRITE && bus_phase >= ACK_SLOT_PHASE) begin
            slave = !ack_low;
        end else if (bus_op == OP_READ) begin
            slave = 1'($urandom_range(0, 1));
        end
        case (sda_src)
            SDA_LOW:    sda_bit = 1'b0;
            SDA_HIGH:   sda_bit = 1'b1;
            SDA_RANDOM: sda_bit = 1'($urandom_range(0, 1));
            default: begin
                sda_bit = bus_sda & slave;
                if (flip_on && $urandom_range(0, 39) == 0) sda_bit = !sda_bit;
            end
        endcase
        i_in_valid <= 1'b1;
        i_cmd      <= c;
        i_wr_data  <= d;
        i_sda_in   <= sda_bit;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        last_inert = (c == OP_IDLE);
        pushed++;
    endtask

    // Feed idle items (random commands too when noise_on is set) until the master is known to be idle
    task automatic wait_bus_idle();
        while (!(last_inert && bus_idle)) begin
            if (noise_on && $urandom_range(0, 11) == 0) begin
                push_item(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
            end else begin
                push_item(OP_IDLE, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic issue_cmd(input logic [3:0] c, input logic [7:0] d);
        wait_bus_idle();
        push_item(c, d);
    endtask

    // Idle the master, drop valid and let every result drain
    task automatic settle();
        wait_bus_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_half(input logic [15:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // One bus transfer: mostly well formed, sometimes broken
    task automatic run_transfer();
        sda_src = ($urandom_range(0, 9) == 0) ? SDA_RANDOM : SDA_BUS;
        flip_on = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 4) == 0) issue_cmd(OP_CLEAR, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4)) begin
                issue_cmd(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
            end
        end else begin
            issue_cmd(OP_START, 8'($urandom_range(0, 255)));
            ack_low = ($urandom_range(0, 4) != 0);
            issue_cmd(OP_WRITE, 8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 3)) begin
                if ($urandom_range(0, 1)) begin
                    issue_cmd(OP_WRITE, 8'($urandom_range(0, 255)));
                end else begin
                    issue_cmd(OP_READ, 8'($urandom_range(0, 255)));
                    issue_cmd($urandom_range(0, 1) ? OP_ACK : OP_NACK,
                              8'($urandom_range(0, 255)));
                end
                if ($urandom_range(0, 5) == 0) issue_cmd(OP_REP, 8'($urandom_range(0, 255)));
                ack_low = ($urandom_range(0, 4) != 0);
            end
            if ($urandom_range(0, 7) != 0) issue_cmd(OP_STOP, 8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int seg_end;
        int rand_base;
        int span;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_in_valid  = 1'b0;
        i_cmd       = OP_IDLE;
        i_wr_data   = '0;
        i_sda_in    = 1'b1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset value of half_period
        issue_cmd(OP_START, 8'h00);
        settle();

        // directed part, zero half_period acts as one
        set_half(16'd0);
        issue_cmd(OP_START, 8'h3C);
        issue_cmd(OP_WRITE, 8'h00);
        issue_cmd(OP_WRITE, 8'hFF);
        wait_bus_idle();
        ack_low = 1'b0;
        issue_cmd(OP_WRITE, 8'hA5);
        wait_bus_idle();
        ack_low = 1'b1;
        issue_cmd(OP_CLEAR, 8'h00);
        sda_src = SDA_LOW;
        issue_cmd(OP_WRITE, 8'hFF);
        wait_bus_idle();
        sda_src = SDA_HIGH;
        issue_cmd(OP_WRITE, 8'h00);
        issue_cmd(OP_READ, 8'h00);
        wait_bus_idle();
        sda_src = SDA_LOW;
        issue_cmd(OP_READ, 8'hFF);
        wait_bus_idle();
        sda_src = SDA_BUS;
        issue_cmd(OP_READ, 8'h81);
        issue_cmd(OP_ACK, 8'h7E);
        issue_cmd(OP_NACK, 8'h18);
        issue_cmd(OP_REP, 8'hE7);
        issue_cmd(OP_WRITE, 8'h5A);
        // ignored while busy
        push_item(OP_STOP, 8'h11);
        push_item(OP_WRITE, 8'h22);
        issue_cmd(OP_STOP, 8'h44);
        wait_bus_idle();
        for (int c = OP_CLEAR + 1; c < 16; c++) push_item(4'(c), 8'h99);
        issue_cmd(OP_CLEAR, 8'h00);
        issue_cmd(OP_CLEAR, 8'hFF);
        settle();

        // random part over several half_period settings
        noise_on  = 1'b1;
        rand_base = pushed;
        span      = ITEM_TARGET - FINAL_ITEMS - rand_base;
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == 0 || seg == SEGMENTS - 1) begin
                set_half(16'd1);
            end else begin
                set_half(16'($urandom_range(2, 6)));
            end
            gaps_on  = (seg != SEGMENTS - 1) && (seg != 2);
            stall_on = (seg != SEGMENTS - 1) && (seg != 3);
            seg_end  = rand_base + span * (seg + 1) / SEGMENTS;
            while (pushed < seg_end) run_transfer();
            settle();
        end

        // largest half_period: load it on a start, feed idle items while the phase holds, drain
        noise_on = 1'b0;
        sda_src  = SDA_BUS;
        set_half(16'hFFFF);
        issue_cmd(OP_START, 8'($urandom_range(0, 255)));
        repeat (8) push_item(OP_IDLE, 8'($urandom_range(0, 255)));
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (fail_count == 0 && outstanding == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
